@@ hdl/rgbhsl_pkg.sv @@
// shared types and constants for the rgb to hsl pixel converter
// no dependencies

package rgbhsl_pkg;

    localparam int unsigned COMP_W = 8;      // width of one color component
    localparam int unsigned H6_W = 11;       // width of sector position times chroma
    localparam int unsigned DIV_STEPS = 4;   // quotient bits resolved per divider stage
    localparam logic [8:0] SUM_WHITE = 9'd510;
    localparam logic [8:0] SUM_HALF = 9'd255;
    localparam logic [8:0] HUE_MAX = 9'd255;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } rgb_pix_t;

    typedef struct packed {
        logic [COMP_W-1:0] hue;
        logic [COMP_W-1:0] saturation;
        logic [COMP_W-1:0] lightness;
    } hsl_pix_t;

    typedef struct packed {
        logic [COMP_W-1:0] lightness;
        logic              hue_zero;
        logic              sat_zero;
    } side_t;

endpackage

@@ hdl/rgbhsl_prep.sv @@
// first stage: max, min, chroma, lightness, hue sector numerator, saturation operands
// depends on rgbhsl_pkg

module rgbhsl_prep
    import rgbhsl_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 16,
    parameter int NUM_W = 28
)
(
    input  logic                  clk,
    input  logic                  en,
    input  rgb_pix_t              pix,
    output logic [NUM_W-1:0]      hue_num,
    output logic [COMP_W-1:0]     hue_div,
    output logic [NUM_W-1:0]      sat_num,
    output logic [COMP_W-1:0]     sat_div,
    output side_t                 side
);

    logic [COMP_W-1:0] mx;
    logic [COMP_W-1:0] mn;
    logic [COMP_W-1:0] chroma;
    logic [8:0]        sum;
    logic [H6_W-1:0]   c_ext;
    logic [H6_W-1:0]   h6;
    logic [15:0]       sat_prod;
    logic [COMP_W-1:0] d;

    logic [NUM_W-1:0]  hue_num_next;
    logic [NUM_W-1:0]  sat_num_next;
    logic [COMP_W-1:0] sat_div_next;
    side_t             side_next;

    logic [NUM_W-1:0]  hue_num_reg;
    logic [COMP_W-1:0] hue_div_reg;
    logic [NUM_W-1:0]  sat_num_reg;
    logic [COMP_W-1:0] sat_div_reg;
    side_t             side_reg;

    always_comb
    begin
        mx = pix.red;
        if (pix.green > mx)
        begin
            mx = pix.green;
        end
        if (pix.blue > mx)
        begin
            mx = pix.blue;
        end
        mn = pix.red;
        if (pix.green < mn)
        begin
            mn = pix.green;
        end
        if (pix.blue < mn)
        begin
            mn = pix.blue;
        end
        chroma = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        c_ext = H6_W'(chroma);

        // red sector first on ties, then green, then blue
        if (mx == pix.red)
        begin
            if (pix.green >= pix.blue)
            begin
                h6 = H6_W'(pix.green) - H6_W'(pix.blue);
            end
            else
            begin
                h6 = H6_W'(6) * c_ext - (H6_W'(pix.blue) - H6_W'(pix.green));
            end
        end
        else if (mx == pix.green)
        begin
            h6 = (c_ext << 1) + H6_W'(pix.blue) - H6_W'(pix.red);
        end
        else
        begin
            h6 = (c_ext << 2) + H6_W'(pix.red) - H6_W'(pix.green);
        end

        sat_prod = {chroma, 8'd0} - {8'd0, chroma};
        if (sum < SUM_HALF)
        begin
            d = sum[COMP_W-1:0];
        end
        else
        begin
            d = COMP_W'(SUM_WHITE - sum);
        end

        hue_num_next = NUM_W'(h6) << HUE_FRAC_BITS;
        sat_num_next = NUM_W'(sat_prod);
        sat_div_next = d;
        side_next.lightness = sum[8:1];
        side_next.hue_zero = (chroma == '0);
        side_next.sat_zero = (sum == '0) || (sum == SUM_WHITE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_num_reg <= hue_num_next;
            hue_div_reg <= chroma;
            sat_num_reg <= sat_num_next;
            sat_div_reg <= sat_div_next;
            side_reg <= side_next;
        end
    end

    assign hue_num = hue_num_reg;
    assign hue_div = hue_div_reg;
    assign sat_num = sat_num_reg;
    assign sat_div = sat_div_reg;
    assign side = side_reg;

endmodule

@@ hdl/rgbhsl_div_stage.sv @@
// one stage of the restoring divider pipeline, hue and saturation lanes side by side
// depends on rgbhsl_pkg

module rgbhsl_div_stage
    import rgbhsl_pkg::*;
#(
    parameter int NUM_W = 28
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [COMP_W-1:0] hue_rem_in,
    input  logic [NUM_W-1:0]  hue_work_in,
    input  logic [COMP_W-1:0] hue_div_in,
    input  logic [COMP_W-1:0] sat_rem_in,
    input  logic [NUM_W-1:0]  sat_work_in,
    input  logic [COMP_W-1:0] sat_div_in,
    input  side_t             side_in,
    output logic [COMP_W-1:0] hue_rem,
    output logic [NUM_W-1:0]  hue_work,
    output logic [COMP_W-1:0] hue_div,
    output logic [COMP_W-1:0] sat_rem,
    output logic [NUM_W-1:0]  sat_work,
    output logic [COMP_W-1:0] sat_div,
    output side_t             side
);

    // work holds the dividend bits still to come at the top, quotient bits shift in below
    function automatic logic [COMP_W+NUM_W-1:0] div_steps(
        input logic [COMP_W-1:0] rem_i,
        input logic [NUM_W-1:0]  work_i,
        input logic [COMP_W-1:0] dv
    );
        logic [COMP_W-1:0] rem_v;
        logic [NUM_W-1:0]  work_v;
        logic [COMP_W:0]   trial;
        logic              qbit;
        rem_v = rem_i;
        work_v = work_i;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial = {rem_v, work_v[NUM_W-1]};
            qbit = (trial >= {1'b0, dv});
            if (qbit)
            begin
                trial = trial - {1'b0, dv};
            end
            rem_v = trial[COMP_W-1:0];
            work_v = {work_v[NUM_W-2:0], qbit};
        end
        return {rem_v, work_v};
    endfunction

    logic [COMP_W+NUM_W-1:0] hue_res;
    logic [COMP_W+NUM_W-1:0] sat_res;

    logic [COMP_W-1:0] hue_rem_reg;
    logic [NUM_W-1:0]  hue_work_reg;
    logic [COMP_W-1:0] hue_div_reg;
    logic [COMP_W-1:0] sat_rem_reg;
    logic [NUM_W-1:0]  sat_work_reg;
    logic [COMP_W-1:0] sat_div_reg;
    side_t             side_reg;

    always_comb
    begin
        hue_res = div_steps(hue_rem_in, hue_work_in, hue_div_in);
        sat_res = div_steps(sat_rem_in, sat_work_in, sat_div_in);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_rem_reg <= hue_res[COMP_W+NUM_W-1:NUM_W];
            hue_work_reg <= hue_res[NUM_W-1:0];
            hue_div_reg <= hue_div_in;
            sat_rem_reg <= sat_res[COMP_W+NUM_W-1:NUM_W];
            sat_work_reg <= sat_res[NUM_W-1:0];
            sat_div_reg <= sat_div_in;
            side_reg <= side_in;
        end
    end

    assign hue_rem = hue_rem_reg;
    assign hue_work = hue_work_reg;
    assign hue_div = hue_div_reg;
    assign sat_rem = sat_rem_reg;
    assign sat_work = sat_work_reg;
    assign sat_div = sat_div_reg;
    assign side = side_reg;

endmodule

@@ hdl/rgbhsl_scale.sv @@
// last two stages: hue quotient times the 8-bit hue scale, then shift, clamp and zero cases
// depends on rgbhsl_pkg

module rgbhsl_scale
    import rgbhsl_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        en_mul,
    input  logic                        en_out,
    input  logic [HUE_FRAC_BITS+2:0]    hue_q,
    input  logic [HUE_FRAC_BITS+5:0]    hue_k,
    input  logic [COMP_W-1:0]           sat_q,
    input  side_t                       side_in,
    output hsl_pix_t                    pix
);

    localparam int QW = HUE_FRAC_BITS + 3;
    localparam int KW = HUE_FRAC_BITS + 6;
    localparam int PW = QW + KW;

    logic [PW-1:0]     prod_reg;
    logic [COMP_W-1:0] sat_reg;
    side_t             side_reg;
    hsl_pix_t          pix_reg;

    logic [8:0]        hue_wide;
    hsl_pix_t          pix_next;

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            prod_reg <= PW'(hue_q) * PW'(hue_k);
            sat_reg <= sat_q;
            side_reg <= side_in;
        end
    end

    always_comb
    begin
        hue_wide = prod_reg[PW-1:2*HUE_FRAC_BITS];
        if (side_reg.hue_zero)
        begin
            pix_next.hue = '0;
        end
        else if (hue_wide > HUE_MAX)
        begin
            pix_next.hue = HUE_MAX[COMP_W-1:0];
        end
        else
        begin
            pix_next.hue = hue_wide[COMP_W-1:0];
        end
        pix_next.saturation = side_reg.sat_zero ? '0 : sat_reg;
        pix_next.lightness = side_reg.lightness;
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix = pix_reg;

endmodule

@@ hdl/rgb_to_hsl_pixel_unit.sv @@
// Converts a stream of 8-bit rgb pixels to 8-bit hue, saturation and lightness, one item
// per clock while the output is taken. It has one operand stage, a restoring divider pipeline
// that resolves four quotient bits per stage for hue and saturation in parallel, one multiply
// stage and one output stage. Every stage stalls only when the item ahead of it is held, so
// bubbles close up under backpressure.
// Depends on rgbhsl_pkg, rgbhsl_prep, rgbhsl_div_stage and rgbhsl_scale.

module rgb_to_hsl_pixel_unit
    import rgbhsl_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rgb_valid,
    output logic     rgb_ready,
    input  rgb_pix_t rgb,
    output logic     hsl_valid,
    input  logic     hsl_ready,
    output hsl_pix_t hsl
);

    localparam int HUE_NUM_W = HUE_FRAC_BITS + H6_W;
    localparam int NS = (HUE_NUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int NUM_W = NS * DIV_STEPS;
    localparam int QW = HUE_FRAC_BITS + 3;
    localparam int KW = HUE_FRAC_BITS + 6;
    localparam int S = NS + 3;
    localparam logic [KW-1:0] HUE_K =
        KW'(((64'd4248 << HUE_FRAC_BITS) + 64'd50) / 64'd100);

    logic [S-1:0] valid_reg;
    logic [S-1:0] valid_next;
    logic [S-1:0] en;

    logic [COMP_W-1:0] hue_rem  [NS+1];
    logic [NUM_W-1:0]  hue_work [NS+1];
    logic [COMP_W-1:0] hue_div  [NS+1];
    logic [COMP_W-1:0] sat_rem  [NS+1];
    logic [NUM_W-1:0]  sat_work [NS+1];
    logic [COMP_W-1:0] sat_div  [NS+1];
    side_t             side     [NS+1];

    always_comb
    begin
        en[S-1] = !valid_reg[S-1] || hsl_ready;
        for (int i = S - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = rgb_valid;
        for (int i = 1; i < S; i++)
        begin
            valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < S; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    assign rgb_ready = en[0];
    assign hsl_valid = valid_reg[S-1];

    assign hue_rem[0] = '0;
    assign sat_rem[0] = '0;

    rgbhsl_prep #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS),
        .NUM_W(NUM_W)
    ) u_prep (
        .clk(clk),
        .en(en[0]),
        .pix(rgb),
        .hue_num(hue_work[0]),
        .hue_div(hue_div[0]),
        .sat_num(sat_work[0]),
        .sat_div(sat_div[0]),
        .side(side[0])
    );

    for (genvar k = 1; k <= NS; k++)
    begin : g_div
        rgbhsl_div_stage #(
            .NUM_W(NUM_W)
        ) u_stage (
            .clk(clk),
            .en(en[k]),
            .hue_rem_in(hue_rem[k-1]),
            .hue_work_in(hue_work[k-1]),
            .hue_div_in(hue_div[k-1]),
            .sat_rem_in(sat_rem[k-1]),
            .sat_work_in(sat_work[k-1]),
            .sat_div_in(sat_div[k-1]),
            .side_in(side[k-1]),
            .hue_rem(hue_rem[k]),
            .hue_work(hue_work[k]),
            .hue_div(hue_div[k]),
            .sat_rem(sat_rem[k]),
            .sat_work(sat_work[k]),
            .sat_div(sat_div[k]),
            .side(side[k])
        );
    end

    rgbhsl_scale #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) u_scale (
        .clk(clk),
        .en_mul(en[NS+1]),
        .en_out(en[NS+2]),
        .hue_q(hue_work[NS][QW-1:0]),
        .hue_k(HUE_K),
        .sat_q(sat_work[NS][COMP_W-1:0]),
        .side_in(side[NS]),
        .pix(hsl)
    );

endmodule

@@ hdl/rgbhsl_checker.sv @@
// port-level checks for rgb_to_hsl_pixel_unit, attached by bind
// depends on rgbhsl_pkg and rgb_to_hsl_pixel_unit

module rgbhsl_checker
    import rgbhsl_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     rgb_valid,
    input logic     rgb_ready,
    input rgb_pix_t rgb,
    input logic     hsl_valid,
    input logic     hsl_ready,
    input hsl_pix_t hsl
);

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid && !hsl_ready |=> hsl_valid && $stable(hsl))
        else $error("result item changed while stalled");

    // no stall upstream unless the output is held
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !hsl_valid || hsl_ready |-> rgb_ready)
        else $error("input stalled with free output");

    // offered input item stays put until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb))
        else $error("input item changed while stalled");

    // white has no saturation
    a_white: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid && hsl.lightness == 8'd255 |-> hsl.saturation == 8'd0)
        else $error("white item with saturation");

endmodule

bind rgb_to_hsl_pixel_unit rgbhsl_checker u_checker (.*);
